/* rtl/sem_pkg.sv */
// Shared types and constants for the Sobel RGB edge magnitude block.
`default_nettype none
package sem_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegHeight = 1'b1;
  localparam logic [10:0] WidthReset  = 11'd640;
  localparam logic [12:0] HeightReset = 13'd480;
  localparam logic [12:0] HeightLimit = 13'd4096;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  red_edge;
    logic [7:0]  green_edge;
    logic [7:0]  blue_edge;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        last_of_run;
    logic        frame_done;
  } pix_out_t;

  typedef logic [23:0] rgb_t;

  // One window snapshot plus the job list that it releases.
  typedef struct packed {
    rgb_t [8:0]  win;
    logic [3:0]  jobs;   // bit0 (0,0), bit1 (0,1), bit2 (1,0), bit3 (1,1)
    logic [11:0] row;
    logic [9:0]  col;
  } job_t;

endpackage
`default_nettype wire

/* rtl/sem_front.sv */
// Front end: counters, line stores and window; classifies released results.
`default_nettype none
module sem_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire sem_pkg::pix_in_t               in_data_i,
  input  wire logic                           cfg_valid_i,
  input  wire logic [sem_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [31:0]                    cfg_data_i,
  output logic                                job_valid_o,
  input  wire logic                           job_ready_i,
  output sem_pkg::job_t                       job_o
);
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [10:0] w_eff;
  logic [12:0] h_eff;
  logic [10:0] col_q;
  logic [12:0] row_q;
  logic        busy_q;
  sem_pkg::pix_in_t px_q;
  sem_pkg::rgb_t win_q [9];
  sem_pkg::rgb_t older_mem [MAX_WIDTH];
  sem_pkg::rgb_t prev_mem [MAX_WIDTH];
  sem_pkg::rgb_t up_rd_q, mid_rd_q;
  logic [10:0] c_eff;
  logic [12:0] r_eff;
  logic        take;
  logic        last_col, bottom;
  sem_pkg::rgb_t up, mid, pxw;
  sem_pkg::rgb_t nwin [9];

  always_comb begin
    w_eff = (width_q < 11'd2) ? 11'd2 :
            ((32'(width_q) > MAX_WIDTH) ? 11'(MAX_WIDTH) : width_q);
    h_eff = (height_q < 13'd2) ? 13'd2 :
            ((height_q > sem_pkg::HeightLimit) ? sem_pkg::HeightLimit : height_q);
    c_eff = (col_q >= w_eff) ? 11'd0 : col_q;
    r_eff = (row_q >= h_eff) ? 13'd0 : row_q;
    last_col = (c_eff == w_eff - 11'd1);
    bottom = (r_eff == h_eff - 13'd1);
    up  = (r_eff >= 13'd2) ? up_rd_q : '0;
    mid = (r_eff >= 13'd1) ? mid_rd_q : '0;
    pxw = {px_q.red_in, px_q.green_in, px_q.blue_in};
    for (int i = 0; i < 3; i++) begin
      nwin[i*3]   = (c_eff == 11'd0) ? '0 : win_q[i*3+1];
      nwin[i*3+1] = (c_eff == 11'd0) ? '0 : win_q[i*3+2];
    end
    nwin[2] = up;
    nwin[5] = mid;
    nwin[8] = pxw;
    job_o.win = {nwin[8], nwin[7], nwin[6], nwin[5], nwin[4],
                 nwin[3], nwin[2], nwin[1], nwin[0]};
    job_o.jobs[0] = (r_eff >= 13'd1) && (c_eff >= 11'd1);
    job_o.jobs[1] = (r_eff >= 13'd1) && last_col;
    job_o.jobs[2] = bottom && (c_eff >= 11'd1);
    job_o.jobs[3] = bottom && last_col;
    job_o.row = r_eff[11:0];
    job_o.col = c_eff[9:0];
  end

  assign in_stall_o  = busy_q;
  assign job_valid_o = busy_q;
  assign take = in_valid_i && !busy_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      px_q     <= in_data_i;
      up_rd_q  <= older_mem[AW'(c_eff)];
      mid_rd_q <= prev_mem[AW'(c_eff)];
    end
    if (busy_q && job_ready_i) begin
      older_mem[AW'(c_eff)] <= mid_rd_q;
      prev_mem[AW'(c_eff)]  <= pxw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sem_pkg::WidthReset;
      height_q <= sem_pkg::HeightReset;
      col_q    <= '0;
      row_q    <= '0;
      busy_q   <= 1'b0;
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sem_pkg::RegWidth:  width_q  <= cfg_data_i[10:0];
        sem_pkg::RegHeight: height_q <= cfg_data_i[12:0];
        default: ;
      endcase
      col_q <= '0;
      row_q <= '0;
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (take) begin
      busy_q <= 1'b1;
    end else if (busy_q && job_ready_i) begin
      busy_q <= 1'b0;
      for (int i = 0; i < 9; i++) win_q[i] <= nwin[i];
      if (last_col) begin
        col_q <= '0;
        row_q <= bottom ? 13'd0 : r_eff + 13'd1;
      end else begin
        col_q <= c_eff + 11'd1;
        row_q <= r_eff;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/sem_queue.sv */
// Two-entry job queue between front and back ends.
`default_nettype none
module sem_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  input  wire sem_pkg::job_t wr_data_i,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i,
  output sem_pkg::job_t      rd_data_o
);
  sem_pkg::job_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end
endmodule
`default_nettype wire

/* rtl/sem_back.sv */
// Back end: per-result Sobel sums, serial rounded square root, output register.
`default_nettype none
module sem_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  output logic               job_ready_o,
  input  wire sem_pkg::job_t job_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output sem_pkg::pix_out_t  out_data_o
);
  typedef enum logic [1:0] {Idle, Sums, Root, Hold} state_e;

  state_e      state_q;
  logic        vld_q;
  logic [3:0]  left_q;
  logic [1:0]  sel_q;
  logic [1:0]  ch_q;
  logic [22:0] rem_q, root_q, bit_q;
  logic [7:0]  res_q [3];
  sem_pkg::pix_out_t out_q;
  logic [1:0]  sel_d;
  logic [22:0] n_ch;
  logic [10:0] gx, gy;
  logic [22:0] sub;

  always_comb begin
    logic [7:0] v [9];
    logic [10:0] a, b;
    logic dr, dc;
    logic signed [22:0] gxw, gyw;
    sel_d = left_q[0] ? 2'd0 : left_q[1] ? 2'd1 : left_q[2] ? 2'd2 : 2'd3;
    dr = sel_q[1];
    dc = sel_q[0];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((i + int'(dr)) < 3 && (j + int'(dc)) < 3)
          v[i*3+j] = 8'(job_i.win[(i + int'(dr))*3 + j + int'(dc)] >> (8*(2 - int'(ch_q))));
        else
          v[i*3+j] = '0;
      end
    end
    a  = 11'(v[2]) + 11'(2 * v[5]) + 11'(v[8]);
    b  = 11'(v[0]) + 11'(2 * v[3]) + 11'(v[6]);
    gx = a - b;
    a  = 11'(v[6]) + 11'(2 * v[7]) + 11'(v[8]);
    b  = 11'(v[0]) + 11'(2 * v[1]) + 11'(v[2]);
    gy = a - b;
    gxw  = 23'($signed(gx));
    gyw  = 23'($signed(gy));
    n_ch = 23'(gxw * gxw + gyw * gyw);
    sub = root_q + bit_q;
  end

  assign job_ready_o = (state_q == Hold) && (left_q == 4'd0) && (!vld_q || !out_stall_i);
  assign out_valid_o = vld_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      vld_q   <= 1'b0;
      left_q  <= '0;
      sel_q   <= '0;
      ch_q    <= '0;
    end else begin
      if (vld_q && !out_stall_i) vld_q <= 1'b0;
      unique case (state_q)
        Idle: begin
          if (job_valid_i) begin
            left_q  <= job_i.jobs;
            state_q <= Hold;
          end
        end
        Hold: begin
          if (left_q == 4'd0) begin
            if (!vld_q || !out_stall_i) state_q <= Idle;
          end else if (!vld_q || !out_stall_i) begin
            sel_q   <= sel_d;
            ch_q    <= 2'd0;
            state_q <= Sums;
          end
        end
        Sums: begin
          rem_q  <= n_ch;
          root_q <= '0;
          bit_q  <= 23'h400000;
          state_q <= Root;
        end
        Root: begin
          if (bit_q == '0) begin
            res_q[ch_q] <= (rem_q > root_q) ?
              ((root_q >= 23'd255) ? 8'd255 : 8'(root_q + 23'd1)) :
              ((root_q > 23'd255) ? 8'd255 : root_q[7:0]);
            if (ch_q == 2'd2) begin
              out_q.red_edge   <= res_q[0];
              out_q.green_edge <= res_q[1];
              out_q.blue_edge  <= (rem_q > root_q) ?
                ((root_q >= 23'd255) ? 8'd255 : 8'(root_q + 23'd1)) :
                ((root_q > 23'd255) ? 8'd255 : root_q[7:0]);
              out_q.out_row <= job_i.row - 12'(!sel_q[1]);
              out_q.out_col <= job_i.col - 10'(!sel_q[0]);
              out_q.last_of_run <= ((left_q & ~(4'd1 << sel_q)) == 4'd0);
              out_q.frame_done  <= (sel_q == 2'd3);
              left_q  <= left_q & ~(4'd1 << sel_q);
              vld_q   <= 1'b1;
              state_q <= Hold;
            end else begin
              ch_q    <= ch_q + 2'd1;
              state_q <= Sums;
            end
          end else begin
            if (rem_q >= sub) begin
              rem_q  <= rem_q - sub;
              root_q <= (root_q >> 1) + bit_q;
            end else begin
              root_q <= root_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/sobel_edge_magnitude_rgb.sv */
// Top level of the Sobel RGB edge magnitude block.
//   channel | handshake             | payload
//   in      | in_valid_i/in_stall_o | sem_pkg::pix_in_t
//   out     | out_valid_o/out_stall_i | sem_pkg::pix_out_t
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// The front takes a new pixel only once the job of the last one has entered the
// queue. Each released result passes a hold state, then per channel a sum state
// and a 12-step serial square root with a finishing state. Each job is taken in
// Idle and leaves the back end from Hold. Reset restores 640x480 and the
// frame start; line store content stays undefined until written.
// The front stalls while its job waits for the queue.
`default_nettype none
module sobel_edge_magnitude_rgb #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire sem_pkg::pix_in_t            in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output sem_pkg::pix_out_t                out_data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [sem_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]                 cfg_data_i
);
  logic job_v, job_r, q_v, q_r;
  sem_pkg::job_t job, qj;

  assign cfg_ready_o = 1'b1;

  sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .job_valid_o(job_v), .job_ready_i(job_r), .job_o(job)
  );

  sem_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(job_v), .wr_ready_o(job_r), .wr_data_i(job),
    .rd_valid_o(q_v), .rd_ready_i(q_r), .rd_data_o(qj)
  );

  sem_back u_back (
    .clk_i, .rst_ni, .job_valid_i(q_v), .job_ready_o(q_r), .job_i(qj),
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule
`default_nettype wire

/* verif/sobel_edge_magnitude_rgb_tb.sv */
// Self-checking testbench for the Sobel RGB edge magnitude block.
`default_nettype none
module sobel_edge_magnitude_rgb_tb;
  timeunit 1ns;
  timeprecision 1ps;

  class edge_scoreboard;
    int unsigned width = 640;
    int unsigned height = 480;
    int unsigned col;
    int unsigned row;
    sem_pkg::rgb_t older_line[1024];
    sem_pkg::rgb_t prev_line[1024];
    sem_pkg::rgb_t win[9];
    sem_pkg::pix_out_t pending[$];
    int errors;
    int kx[9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
    int ky[9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

    function void restart();
      col = 0;
      row = 0;
      foreach (win[i]) win[i] = '0;
    endfunction

    function void set_reg(logic [sem_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
      if (idx == sem_pkg::RegWidth) width = data[10:0];
      else height = data[12:0];
      restart();
    endfunction

    function logic [7:0] magnitude(int sh, int dr, int dc);
      int gx, gy, v, n, r;
      gx = 0;
      gy = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          v = 0;
          if (i + dr < 3 && j + dc < 3) v = (win[(i + dr) * 3 + j + dc] >> sh) & 8'hFF;
          gx += kx[i * 3 + j] * v;
          gy += ky[i * 3 + j] * v;
        end
      end
      n = gx * gx + gy * gy;
      r = 0;
      while ((r + 1) * (r + 1) <= n) r++;
      if (n - r * r > r) r++;
      return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    function sem_pkg::pix_out_t edge_at(int dr, int dc, int r, int c, bit done);
      sem_pkg::pix_out_t o;
      o.red_edge    = magnitude(16, dr, dc);
      o.green_edge  = magnitude(8, dr, dc);
      o.blue_edge   = magnitude(0, dr, dc);
      o.out_row     = r[11:0];
      o.out_col     = c[9:0];
      o.last_of_run = 1'b0;
      o.frame_done  = done;
      return o;
    endfunction

    function void note_pixel(sem_pkg::pix_in_t p);
      int unsigned w, h, c, r;
      sem_pkg::rgb_t px;
      sem_pkg::pix_out_t burst[$];
      bit last_col, bottom;
      w = (width < 2) ? 2 : (width > 1024) ? 1024 : width;
      h = (height < 2) ? 2 : (height > 4096) ? 4096 : height;
      c = (col >= w) ? 0 : col;
      r = (row >= h) ? 0 : row;
      px = {p.red_in, p.green_in, p.blue_in};
      if (c == 0) foreach (win[i]) win[i] = '0;
      for (int i = 0; i < 3; i++) begin
        win[i * 3] = win[i * 3 + 1];
        win[i * 3 + 1] = win[i * 3 + 2];
      end
      win[2] = (r >= 2) ? older_line[c] : '0;
      win[5] = (r >= 1) ? prev_line[c] : '0;
      win[8] = px;
      older_line[c] = prev_line[c];
      prev_line[c] = px;
      last_col = (c == w - 1);
      bottom = (r == h - 1);
      if (r >= 1 && c >= 1) burst.push_back(edge_at(0, 0, r - 1, c - 1, 0));
      if (r >= 1 && last_col) burst.push_back(edge_at(0, 1, r - 1, c, 0));
      if (bottom && c >= 1) burst.push_back(edge_at(1, 0, r, c - 1, 0));
      if (bottom && last_col) burst.push_back(edge_at(1, 1, r, c, 1));
      if (burst.size() > 0) burst[burst.size() - 1].last_of_run = 1'b1;
      foreach (burst[i]) pending.push_back(burst[i]);
      if (last_col) begin
        col = 0;
        row = bottom ? 0 : r + 1;
      end else begin
        col = c + 1;
        row = r;
      end
    endfunction

    function void cmp(string name, int e, int a);
      if (e != a) begin
        $error("%s expected %0d actual %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(sem_pkg::pix_out_t a);
      sem_pkg::pix_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result row %0d col %0d", a.out_row, a.out_col);
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("red_edge", e.red_edge, a.red_edge);
      cmp("green_edge", e.green_edge, a.green_edge);
      cmp("blue_edge", e.blue_edge, a.blue_edge);
      cmp("out_row", e.out_row, a.out_row);
      cmp("out_col", e.out_col, a.out_col);
      cmp("last_of_run", e.last_of_run, a.last_of_run);
      cmp("frame_done", e.frame_done, a.frame_done);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  sem_pkg::pix_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  sem_pkg::pix_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [sem_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  edge_scoreboard sb = new();
  int send_idle_pct;
  int stall_pct;
  int hold_cnt;
  int quiet_cycles;

  sobel_edge_magnitude_rgb u_dut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (hold_cnt > 0) begin
      out_stall_i <= 1'b1;
      hold_cnt--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("sobel_edge_magnitude_rgb test failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [sem_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(sem_pkg::pix_in_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(p);
  endtask

  function automatic logic [7:0] chan();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic sem_pkg::pix_in_t random_pixel();
    return '{red_in: chan(), green_in: chan(), blue_in: chan()};
  endfunction

  initial begin
    sem_pkg::pix_in_t p;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x3 checkerboard with a coloured centre, then tiny frame from clamped low sizes
    write_reg(sem_pkg::RegWidth, 32'd3);
    write_reg(sem_pkg::RegHeight, 32'd3);
    for (int i = 0; i < 9; i++) begin
      p = (i % 2) ? 24'hFFFFFF : (i == 4) ? 24'h0F80F0 : 24'h000000;
      send_pixel(p);
    end
    in_valid_i <= 1'b0;
    wait_idle();
    write_reg(sem_pkg::RegWidth, 32'd0);
    write_reg(sem_pkg::RegHeight, 32'd1);
    send_pixel(24'hFF00FF);
    send_pixel(24'h00FF00);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    in_valid_i <= 1'b0;
    wait_idle();
    // oversized values clamp to the largest frame
    write_reg(sem_pkg::RegWidth, 32'hFFFF_FFFF);
    write_reg(sem_pkg::RegHeight, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send_pixel(random_pixel());
    in_valid_i <= 1'b0;
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 71 : 0;
      stall_pct = (ph == 0) ? 71 : (ph == 1) ? 23 : 0;
      write_reg(sem_pkg::RegWidth,
                {8'($urandom_range(255, 0)), 13'd0, 11'($urandom_range(2, 9))});
      write_reg(sem_pkg::RegHeight,
                {8'($urandom_range(255, 0)), 11'd0, 13'($urandom_range(2, 6))});
      for (int i = 0; i < 65; i++) begin
        if (ph == 0 && i == 20) hold_cnt = 400;
        if (ph == 1 && i == 30) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (sb.pending.size() != 0) @(posedge clk_i);
        end
        send_pixel(random_pixel());
      end
      in_valid_i <= 1'b0;
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("sobel_edge_magnitude_rgb test passed");
    end else begin
      $display("sobel_edge_magnitude_rgb test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
